### src/binary_trie_address_to_server_map_top_assert.svh
// assertion macros for the address to server map checker
// no dependencies; taken in by the checker file
`ifndef BINARY_TRIE_ADDRESS_TO_SERVER_MAP_TOP_ASSERT_SVH
`define BINARY_TRIE_ADDRESS_TO_SERVER_MAP_TOP_ASSERT_SVH

// same-cycle implication
`define BTASM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTASM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/btasm_pkg.sv
// shared constants, codes and types of the address to server map
// no dependencies
`default_nettype none

package btasm_pkg;

    localparam int NODES_DEF    = 4096;
    localparam int KEY_BITS_DEF = 32;
    localparam int SERVERS_DEF  = 128;

    localparam int ADDR_W   = 32;
    localparam int SERVER_W = 7;
    localparam int STATUS_W = 2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_EXACT    = 2'd0;
    localparam status_t ST_FALLBACK = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    typedef struct packed {
        logic                valid;
        logic                op;
        logic [SERVER_W-1:0] sid;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic [SERVER_W-1:0] server;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

### src/binary_trie_address_to_server_map_top.sv
// Address to server map. Input channel s_*: operation (0 lookup, 1 insert),
// 32-bit address and server id. Result channel m_*: one result item for
// every input item, server id and status (0 exact or inserted, 1 fallback,
// 2 table empty, 3 pool full). Both channels use valid and ready.
// An item walks the trie one level per cycle through the node memory, whose
// single registered read port sets the pace. A refused insert or a lookup of
// an empty table skips the walk and goes from the root straight to its result.
// One item is in the walker at a time; the next item is taken while the
// previous result still sits in the output register.
// A stalled receiver holds the result in the output register; a walker that
// finishes behind it waits, and s_ready stays low until it has handed over.
// Reset clears the root links and sets the pool counter to its first node;
// the node memory needs no clearing pass, a node is written when allocated.
// depends on btasm_pkg and btasm_walk
`default_nettype none

module binary_trie_address_to_server_map_top #(
    parameter int NODES    = btasm_pkg::NODES_DEF,
    parameter int KEY_BITS = btasm_pkg::KEY_BITS_DEF,
    parameter int SERVERS  = btasm_pkg::SERVERS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [btasm_pkg::ADDR_W-1:0]       s_address,
    input  wire logic [btasm_pkg::SERVER_W-1:0]     s_server_id,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [btasm_pkg::SERVER_W-1:0]     m_result_server,
    output btasm_pkg::status_t                      m_status
);

    import btasm_pkg::*;

    localparam int XW = (KEY_BITS > ADDR_W) ? KEY_BITS : ADDR_W;

    cmd_t                cmd;
    result_t             res;
    logic                walk_ready;
    logic                res_take;
    logic [XW-1:0]       addr_ext;
    logic [SERVER_W-1:0] sid_rem;

    logic                m_valid_reg, m_valid_next;
    logic [SERVER_W-1:0] m_server_reg, m_server_next;
    status_t             m_status_reg, m_status_next;

    // id modulo SERVERS by restoring subtraction of shifted constants
    always_comb begin
        sid_rem = s_server_id;
        for (int k = SERVER_W - 1; k >= 0; k--) begin
            if (int'(sid_rem) >= (SERVERS << k)) begin
                sid_rem = sid_rem - SERVER_W'(SERVERS << k);
            end
        end
    end

    assign addr_ext  = XW'(s_address);
    assign s_ready   = walk_ready;
    assign cmd.valid = s_valid && walk_ready;
    assign cmd.op    = s_operation;
    assign cmd.sid   = sid_rem;

    btasm_walk #(
        .NODES   (NODES),
        .KEY_BITS(KEY_BITS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .key     (addr_ext[KEY_BITS-1:0]),
        .ready   (walk_ready),
        .res     (res),
        .res_take(res_take)
    );

    assign res_take = res.valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_server_next = m_server_reg;
        m_status_next = m_status_reg;
        priority if (res_take) begin
            m_valid_next  = 1'b1;
            m_server_next = res.server;
            m_status_next = res.status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_server_reg <= m_server_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_server = m_server_reg;
    assign m_status        = m_status_reg;

endmodule

`default_nettype wire

### src/btasm_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module btasm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/btasm_walk.sv
// trie walker: root links, node pool counter and the node memory sequencer
// depends on btasm_pkg and btasm_ram
`default_nettype none

module btasm_walk #(
    parameter int NODES    = btasm_pkg::NODES_DEF,
    parameter int KEY_BITS = btasm_pkg::KEY_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire btasm_pkg::cmd_t     cmd,
    input  wire logic [KEY_BITS-1:0] key,
    output logic                     ready,
    output btasm_pkg::result_t       res,
    input  wire logic                res_take
);

    import btasm_pkg::*;

    localparam int LW  = $clog2(NODES);
    localparam int NFW = $clog2(NODES + 1);
    localparam int DW  = $clog2(KEY_BITS + 1);
    localparam int EW  = 2 * LW + 1 + SERVER_W;

    localparam logic [NFW-1:0] FREE_LIMIT = NFW'(NODES - KEY_BITS);
    localparam logic [DW-1:0]  DEPTH_END  = DW'(KEY_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOT  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic [SERVER_W-1:0] sid_reg, sid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic                fb_reg, fb_next;
    logic [NFW-1:0]      nf_reg, nf_next;
    logic [LW-1:0]       root_l_reg, root_l_next;
    logic [LW-1:0]       root_r_reg, root_r_next;
    logic [SERVER_W-1:0] server_reg, server_next;
    status_t             status_reg, status_next;

    logic          we, re;
    logic [LW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic                bit_now;
    logic                last;
    logic                pool_low;
    logic [LW-1:0]       nf_link;
    logic [LW-1:0]       rd_l, rd_r, rd_child, rd_fb;
    logic                rd_end;
    logic [SERVER_W-1:0] rd_server;
    logic [LW-1:0]       root_child, root_fb;

    btasm_ram #(
        .WIDTH(EW),
        .DEPTH(NODES)
    ) u_node_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign bit_now    = key_reg[KEY_BITS-1];
    assign last       = (depth_reg == DEPTH_END);
    assign pool_low   = (nf_reg > FREE_LIMIT);
    assign nf_link    = LW'(nf_reg);
    assign rd_l       = rdata[EW-1 -: LW];
    assign rd_r       = rdata[EW-1-LW -: LW];
    assign rd_end     = rdata[SERVER_W];
    assign rd_server  = rdata[SERVER_W-1:0];
    assign rd_child   = bit_now ? rd_r : rd_l;
    assign rd_fb      = (rd_l != '0) ? rd_l : rd_r;
    assign root_child = bit_now ? root_r_reg : root_l_reg;
    assign root_fb    = (root_l_reg != '0) ? root_l_reg : root_r_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        sid_next    = sid_reg;
        key_next    = key_reg;
        depth_next  = depth_reg;
        cur_next    = cur_reg;
        fb_next     = fb_reg;
        nf_next     = nf_reg;
        root_l_next = root_l_reg;
        root_r_next = root_r_reg;
        server_next = server_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd.valid) begin
                    op_next    = cmd.op;
                    sid_next   = cmd.sid;
                    key_next   = key;
                    depth_next = '0;
                    fb_next    = 1'b0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (op_reg == OP_INSERT) begin
                    if (pool_low) begin
                        server_next = sid_reg;
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end else if (root_child != '0) begin
                        cur_next   = root_child;
                        re         = 1'b1;
                        raddr      = root_child;
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                        state_next = S_CHK;
                    end else begin
                        if (bit_now) begin
                            root_r_next = nf_link;
                        end else begin
                            root_l_next = nf_link;
                        end
                        cur_next   = nf_link;
                        nf_next    = nf_reg + NFW'(1);
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                        state_next = S_ALLOC;
                    end
                end else begin
                    if (root_l_reg == '0 && root_r_reg == '0) begin
                        server_next = '0;
                        status_next = ST_EMPTY;
                        state_next  = S_FIN;
                    end else begin
                        if (root_child != '0) begin
                            cur_next = root_child;
                            raddr    = root_child;
                        end else begin
                            fb_next  = 1'b1;
                            cur_next = root_fb;
                            raddr    = root_fb;
                        end
                        re         = 1'b1;
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (op_reg == OP_INSERT) begin
                    if (last) begin
                        we          = 1'b1;
                        wdata       = {rd_l, rd_r, 1'b1, sid_reg};
                        server_next = sid_reg;
                        status_next = ST_EXACT;
                        state_next  = S_FIN;
                    end else if (rd_child != '0) begin
                        cur_next   = rd_child;
                        re         = 1'b1;
                        raddr      = rd_child;
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                    end else begin
                        we         = 1'b1;
                        wdata      = bit_now ? {rd_l, nf_link, rd_end, rd_server}
                                             : {nf_link, rd_r, rd_end, rd_server};
                        cur_next   = nf_link;
                        nf_next    = nf_reg + NFW'(1);
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                        state_next = S_ALLOC;
                    end
                end else begin
                    if (last) begin
                        server_next = rd_server;
                        status_next = fb_reg ? ST_FALLBACK : ST_EXACT;
                        state_next  = S_FIN;
                    end else if (!fb_reg && rd_child != '0) begin
                        cur_next   = rd_child;
                        re         = 1'b1;
                        raddr      = rd_child;
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                    end else if (rd_fb != '0) begin
                        fb_next    = 1'b1;
                        cur_next   = rd_fb;
                        re         = 1'b1;
                        raddr      = rd_fb;
                        depth_next = depth_reg + DW'(1);
                        key_next   = key_reg << 1;
                    end else begin
                        // dead end: report this node
                        server_next = rd_server;
                        status_next = ST_FALLBACK;
                        state_next  = S_FIN;
                    end
                end
            end
            S_ALLOC: begin
                we = 1'b1;
                if (last) begin
                    wdata       = {{LW{1'b0}}, {LW{1'b0}}, 1'b1, sid_reg};
                    server_next = sid_reg;
                    status_next = ST_EXACT;
                    state_next  = S_FIN;
                end else begin
                    wdata      = bit_now ? {{LW{1'b0}}, nf_link, 1'b0, {SERVER_W{1'b0}}}
                                         : {nf_link, {LW{1'b0}}, 1'b0, {SERVER_W{1'b0}}};
                    cur_next   = nf_link;
                    nf_next    = nf_reg + NFW'(1);
                    depth_next = depth_reg + DW'(1);
                    key_next   = key_reg << 1;
                end
            end
            S_FIN: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            nf_reg     <= NFW'(1);
            root_l_reg <= '0;
            root_r_reg <= '0;
        end else begin
            state_reg  <= state_next;
            nf_reg     <= nf_next;
            root_l_reg <= root_l_next;
            root_r_reg <= root_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        sid_reg    <= sid_next;
        key_reg    <= key_next;
        depth_reg  <= depth_next;
        cur_reg    <= cur_next;
        fb_reg     <= fb_next;
        server_reg <= server_next;
        status_reg <= status_next;
    end

    assign ready      = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_FIN);
    assign res.server = server_reg;
    assign res.status = status_reg;

endmodule

`default_nettype wire

### src/btasm_checker.sv
// port-level checker for the address to server map, with its bind
// depends on btasm_pkg and the assertion macro header
`default_nettype none
`include "binary_trie_address_to_server_map_top_assert.svh"

module btasm_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [btasm_pkg::SERVER_W-1:0] m_result_server,
    input  wire btasm_pkg::status_t             m_status
);

    import btasm_pkg::*;

    // items taken in whose results are not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        unique case ({in_acc, out_acc})
            2'b10:   pend_next = pend_reg + 2'd1;
            2'b01:   pend_next = pend_reg - 2'd1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `BTASM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_server) && $stable(m_status), "result item changed while stalled")
    `BTASM_ASSERT_IMPLY(a_no_phantom, aclk, aresetn, m_valid, pend_reg != 2'd0, "result item without an accepted item")
    `BTASM_ASSERT_IMPLY(a_two_in_flight, aclk, aresetn, pend_reg == 2'd2, !s_ready, "item taken with two results pending")
    `BTASM_ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_valid && m_status == ST_EMPTY, m_result_server == '0, "empty table result with non-zero server")

endmodule

bind binary_trie_address_to_server_map_top btasm_checker u_btasm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_server(m_result_server),
    .m_status       (m_status)
);

`default_nettype wire
